// ===== design/rmq_pkg.sv =====
package rmq_pkg;

	localparam int DEF_DATA_WIDTH = 16;
	localparam int DEF_FRAC_BITS  = 14;

	// magnitude bits of a component before normalization
	localparam int QMAG_W = 30;
	localparam logic [QMAG_W-1:0] QLIM = '1;

	typedef enum logic [1:0] {
		PIV_W = 2'd0,
		PIV_X = 2'd1,
		PIV_Y = 2'd2,
		PIV_Z = 2'd3
	} piv_t;

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== design/rmq_front.sv =====
module rmq_front #(
	parameter int DW = 16,
	parameter int FB = 14,
	parameter int AW = 19
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [DW-1:0] m00,
	input  logic signed [DW-1:0] m01,
	input  logic signed [DW-1:0] m02,
	input  logic signed [DW-1:0] m10,
	input  logic signed [DW-1:0] m11,
	input  logic signed [DW-1:0] m12,
	input  logic signed [DW-1:0] m20,
	input  logic signed [DW-1:0] m21,
	input  logic signed [DW-1:0] m22,
	output logic                 out_vld,
	output rmq_pkg::piv_t        piv,
	output logic [AW-2:0]        arg,
	output logic [2:0][DW:0]     mag,
	output logic [2:0]           neg
);
	import rmq_pkg::*;

	localparam logic signed [AW-1:0] ONE = {{(AW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

	function automatic logic signed [AW-1:0] ext(input logic signed [DW-1:0] x);
		return {{(AW-DW){x[DW-1]}}, x};
	endfunction

	function automatic logic signed [DW:0] ex1(input logic signed [DW-1:0] x);
		return {x[DW-1], x};
	endfunction

	logic signed [AW-1:0] trace;
	logic                 vld_s1;
	logic                 tpos_s1, gx_s1, gy_s1;
	logic signed [AW-1:0] argw_s1, argx_s1, argy_s1, argz_s1;
	logic signed [DW:0]   da_s1, db_s1, dc_s1, s01_s1, s02_s1, s12_s1;

	assign trace = ext(m00) + ext(m11) + ext(m22);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tpos_s1 <= !trace[AW-1] && (trace != '0);
			gx_s1   <= (m00 > m11) && (m00 > m22);
			gy_s1   <= (m11 > m22);
			argw_s1 <= trace + ONE;
			argx_s1 <= ext(m00) - ext(m11) - ext(m22) + ONE;
			argy_s1 <= ext(m11) - ext(m00) - ext(m22) + ONE;
			argz_s1 <= ext(m22) - ext(m00) - ext(m11) + ONE;
			da_s1   <= ex1(m21) - ex1(m12);
			db_s1   <= ex1(m02) - ex1(m20);
			dc_s1   <= ex1(m10) - ex1(m01);
			s01_s1  <= ex1(m01) + ex1(m10);
			s02_s1  <= ex1(m02) + ex1(m20);
			s12_s1  <= ex1(m12) + ex1(m21);
		end
	end

	piv_t                    piv_c;
	logic signed [AW-1:0]    arg_c;
	logic signed [2:0][DW:0] num_c;

	always_comb begin
		if (tpos_s1) begin
			piv_c = PIV_W;
		end else if (gx_s1) begin
			piv_c = PIV_X;
		end else if (gy_s1) begin
			piv_c = PIV_Y;
		end else begin
			piv_c = PIV_Z;
		end
		unique case (piv_c)
			PIV_W: begin
				arg_c = argw_s1;
				num_c = {dc_s1, db_s1, da_s1};
			end
			PIV_X: begin
				arg_c = argx_s1;
				num_c = {s02_s1, s01_s1, da_s1};
			end
			PIV_Y: begin
				arg_c = argy_s1;
				num_c = {s12_s1, s01_s1, db_s1};
			end
			PIV_Z: begin
				arg_c = argz_s1;
				num_c = {s12_s1, s02_s1, dc_s1};
			end
			default: begin
				arg_c = argw_s1;
				num_c = {dc_s1, db_s1, da_s1};
			end
		endcase
	end

	logic                vld_s2;
	piv_t                piv_s2;
	logic [AW-2:0]       arg_s2;
	logic [2:0][DW:0]    mag_s2;
	logic [2:0]          neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			piv_s2 <= piv_c;
			// negative root argument clamps to zero
			arg_s2 <= arg_c[AW-1] ? '0 : arg_c[AW-2:0];
			for (int l = 0; l < 3; l++) begin
				neg_s2[l] <= num_c[l][DW];
				mag_s2[l] <= num_c[l][DW] ? (DW+1)'(-num_c[l]) : num_c[l];
			end
		end
	end

	assign out_vld = vld_s2;
	assign piv     = piv_s2;
	assign arg     = arg_s2;
	assign mag     = mag_s2;
	assign neg     = neg_s2;

endmodule

// ===== design/rmq_isqrt.sv =====
module rmq_isqrt #(
	parameter int IN_W = 32,
	parameter int SB_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [IN_W-1:0]   rad,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_vld,
	output logic [IN_W/2-1:0] root,
	output logic [SB_W-1:0]   out_sb
);
	localparam int RW  = IN_W / 2;
	localparam int RMW = RW + 1;

	// one result bit per stage, remainder and partial root travel down
	logic [RMW-1:0]  rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [IN_W-1:0] rad_s  [RW];
	logic [SB_W-1:0] sb_s   [RW];
	logic            vld_s  [RW];

	for (genvar gi = 0; gi < RW; gi++) begin : g_stage
		logic [RMW-1:0]  rem_i;
		logic [RW-1:0]   root_i;
		logic [IN_W-1:0] rad_i;
		logic [SB_W-1:0] sb_i;
		logic            vld_i;
		logic [RW+2:0]   cur;
		logic [RW+2:0]   trial;
		logic            take;

		if (gi == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
			assign sb_i   = in_sb;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[gi-1];
			assign root_i = root_s[gi-1];
			assign rad_i  = rad_s[gi-1];
			assign sb_i   = sb_s[gi-1];
			assign vld_i  = vld_s[gi-1];
		end

		assign cur   = {rem_i, rad_i[IN_W-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else if (en) begin
				vld_s[gi] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[gi]  <= take ? RMW'(cur - trial) : RMW'(cur);
				root_s[gi] <= {root_i[RW-2:0], take};
				rad_s[gi]  <= rad_i << 2;
				sb_s[gi]   <= sb_i;
			end
		end
	end

	assign out_vld = vld_s[RW-1];
	assign root    = root_s[RW-1];
	assign out_sb  = sb_s[RW-1];

endmodule

// ===== design/rmq_div.sv =====
module rmq_div #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 17,
	parameter int QUO_W = 30,
	parameter int LANES = 3,
	parameter int SB_W  = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [LANES-1:0][NUM_W-1:0] num,
	input  logic [DEN_W-1:0]            den,
	input  logic [SB_W-1:0]             in_sb,
	output logic                        out_vld,
	output logic [LANES-1:0][QUO_W-1:0] quo,
	output logic [LANES-1:0]            ovf,
	output logic [SB_W-1:0]             out_sb
);
	import rmq_pkg::*;

	localparam int CW = max2(NUM_W, DEN_W);
	localparam int NS = QUO_W + 1;

	// entry stage checks whether the quotient fits, then one bit per stage
	logic [LANES-1:0][DEN_W-1:0] rem_s [NS];
	logic [LANES-1:0][QUO_W-1:0] lo_s  [NS];
	logic [LANES-1:0][QUO_W-1:0] quo_s [NS];
	logic [LANES-1:0]            ovf_s [NS];
	logic [DEN_W-1:0]            den_s [NS];
	logic [SB_W-1:0]             sb_s  [NS];
	logic                        vld_s [NS];

	logic [LANES-1:0][CW-1:0]    hi;
	logic [LANES-1:0]            ovf_e;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			hi[l]    = CW'(num[l] >> QUO_W);
			ovf_e[l] = (hi[l] >= CW'(den));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= DEN_W'(hi[l]);
				lo_s[0][l]  <= QUO_W'(num[l]);
			end
			quo_s[0] <= '0;
			ovf_s[0] <= ovf_e;
			den_s[0] <= den;
			sb_s[0]  <= in_sb;
		end
	end

	for (genvar gi = 1; gi < NS; gi++) begin : g_stage
		logic [LANES-1:0][DEN_W:0]   cur;
		logic [LANES-1:0]            take;
		logic [LANES-1:0][DEN_W-1:0] nrem;
		logic [LANES-1:0][QUO_W-1:0] nlo;
		logic [LANES-1:0][QUO_W-1:0] nquo;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				cur[l]  = {rem_s[gi-1][l], lo_s[gi-1][l][QUO_W-1]};
				take[l] = (cur[l] >= {1'b0, den_s[gi-1]});
				nrem[l] = take[l] ? DEN_W'(cur[l] - {1'b0, den_s[gi-1]}) : DEN_W'(cur[l]);
				nlo[l]  = lo_s[gi-1][l] << 1;
				nquo[l] = {quo_s[gi-1][l][QUO_W-2:0], take[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else if (en) begin
				vld_s[gi] <= vld_s[gi-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[gi] <= nrem;
				lo_s[gi]  <= nlo;
				quo_s[gi] <= nquo;
				ovf_s[gi] <= ovf_s[gi-1];
				den_s[gi] <= den_s[gi-1];
				sb_s[gi]  <= sb_s[gi-1];
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign quo     = quo_s[NS-1];
	assign ovf     = ovf_s[NS-1];
	assign out_sb  = sb_s[NS-1];

endmodule

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
// channel  direction  handshake                payload
// matrix   in         mat_valid / mat_ready    r00 .. r22
// quat     out        quat_valid / quat_ready  quat_x quat_y quat_z quat_w pivot_used status
//
// fully pipelined: one request enters per cycle while quat_ready is high or the output
// register is empty. the depth comes from the front stages, the two bit-per-stage square
// roots, the two bit-per-stage dividers, the sum of squares and the output register;
// the first square root gives a 16-bit root at the defaults. a stalled output freezes
// every stage at once, so nothing is lost or repeated. reset clears only the valid bits.
module rotation_matrix_to_quaternion_unit #(
	parameter int DATA_WIDTH = rmq_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = rmq_pkg::DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         mat_valid,
	output logic                         mat_ready,
	input  logic signed [DATA_WIDTH-1:0] r00,
	input  logic signed [DATA_WIDTH-1:0] r01,
	input  logic signed [DATA_WIDTH-1:0] r02,
	input  logic signed [DATA_WIDTH-1:0] r10,
	input  logic signed [DATA_WIDTH-1:0] r11,
	input  logic signed [DATA_WIDTH-1:0] r12,
	input  logic signed [DATA_WIDTH-1:0] r20,
	input  logic signed [DATA_WIDTH-1:0] r21,
	input  logic signed [DATA_WIDTH-1:0] r22,
	output logic                         quat_valid,
	input  logic                         quat_ready,
	output logic signed [DATA_WIDTH-1:0] quat_x,
	output logic signed [DATA_WIDTH-1:0] quat_y,
	output logic signed [DATA_WIDTH-1:0] quat_z,
	output logic signed [DATA_WIDTH-1:0] quat_w,
	output logic [1:0]                   pivot_used,
	output logic                         status
);
	import rmq_pkg::*;

	localparam int DW   = DATA_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int AW   = max2(DW + 2, FB + 1) + 1;
	localparam int SN0  = AW - 1 + FB;
	localparam int SN   = SN0 + (SN0 % 2);
	localparam int RW   = SN / 2;
	localparam int SW   = RW + 1;
	localparam int PVW  = max2(RW - 1, QMAG_W);
	localparam int N1W  = DW + 1 + FB;
	localparam int SQ_W = 2 * QMAG_W;
	localparam int PS_W = SQ_W + 1;
	localparam int TS_W = SQ_W + 2;
	localparam int NRW  = TS_W / 2;
	localparam int N2W  = QMAG_W + FB;

	localparam logic [DW-1:0] OMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] OMIN = {1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		piv_t             piv;
		logic [2:0]       neg;
		logic [2:0][DW:0] mag;
	} sb1_t;

	typedef struct packed {
		piv_t              piv;
		logic [2:0]        neg;
		logic [QMAG_W-1:0] pmag;
		logic              zero;
	} sb2_t;

	typedef struct packed {
		piv_t                   piv;
		logic [3:0]             neg;
		logic [3:0][QMAG_W-1:0] mag;
		logic                   zero;
	} sb3_t;

	typedef struct packed {
		piv_t       piv;
		logic [3:0] neg;
		logic       zero;
	} sb4_t;

	logic en;
	logic vld_s4;

	assign en        = !vld_s4 || quat_ready;
	assign mat_ready = en;

	// pivot choice, root argument and numerators
	logic             f_vld;
	piv_t             f_piv;
	logic [AW-2:0]    f_arg;
	logic [2:0][DW:0] f_mag;
	logic [2:0]       f_neg;

	rmq_front #(.DW(DW), .FB(FB), .AW(AW)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(mat_valid),
		.m00(r00), .m01(r01), .m02(r02),
		.m10(r10), .m11(r11), .m12(r12),
		.m20(r20), .m21(r21), .m22(r22),
		.out_vld(f_vld), .piv(f_piv), .arg(f_arg), .mag(f_mag), .neg(f_neg)
	);

	sb1_t          r1_in_sb, r1_sb;
	logic          r1_vld;
	logic [RW-1:0] r1_root;

	assign r1_in_sb = '{piv: f_piv, neg: f_neg, mag: f_mag};

	rmq_isqrt #(.IN_W(SN), .SB_W($bits(sb1_t))) u_root (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(f_vld),
		.rad(SN'({f_arg, {FB{1'b0}}})), .in_sb(r1_in_sb),
		.out_vld(r1_vld), .root(r1_root), .out_sb(r1_sb)
	);

	// s = 2 * root, pivot component = root / 2
	logic [PVW-1:0]            pvx;
	sb2_t                      d1_in_sb, d1_sb;
	logic [2:0][N1W-1:0]       d1_num;
	logic                      d1_vld;
	logic [2:0][QMAG_W-1:0]    d1_quo;
	logic [2:0]                d1_ovf;

	assign pvx = PVW'(r1_root >> 1);
	assign d1_in_sb = '{
		piv:  r1_sb.piv,
		neg:  r1_sb.neg,
		pmag: (pvx > PVW'(QLIM)) ? QLIM : QMAG_W'(pvx),
		zero: (r1_root == '0)
	};

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			d1_num[l] = {r1_sb.mag[l], {FB{1'b0}}};
		end
	end

	rmq_div #(
		.NUM_W(N1W), .DEN_W(SW), .QUO_W(QMAG_W), .LANES(3), .SB_W($bits(sb2_t))
	) u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(r1_vld),
		.num(d1_num), .den({r1_root, 1'b0}), .in_sb(d1_in_sb),
		.out_vld(d1_vld), .quo(d1_quo), .ovf(d1_ovf), .out_sb(d1_sb)
	);

	// place the components as x y z w (index 0..3)
	logic [2:0][QMAG_W-1:0] sat;
	logic [3:0][QMAG_W-1:0] qm_c;
	logic [3:0]             qn_c;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sat[l] = d1_ovf[l] ? QLIM : d1_quo[l];
		end
		unique case (d1_sb.piv)
			PIV_W: begin
				qm_c = {d1_sb.pmag, sat[2], sat[1], sat[0]};
				qn_c = {1'b0, d1_sb.neg[2], d1_sb.neg[1], d1_sb.neg[0]};
			end
			PIV_X: begin
				qm_c = {sat[0], sat[2], sat[1], d1_sb.pmag};
				qn_c = {d1_sb.neg[0], d1_sb.neg[2], d1_sb.neg[1], 1'b0};
			end
			PIV_Y: begin
				qm_c = {sat[0], sat[2], d1_sb.pmag, sat[1]};
				qn_c = {d1_sb.neg[0], d1_sb.neg[2], 1'b0, d1_sb.neg[1]};
			end
			PIV_Z: begin
				qm_c = {sat[0], d1_sb.pmag, sat[2], sat[1]};
				qn_c = {d1_sb.neg[0], 1'b0, d1_sb.neg[2], d1_sb.neg[1]};
			end
			default: begin
				qm_c = {d1_sb.pmag, sat[2], sat[1], sat[0]};
				qn_c = {1'b0, d1_sb.neg[2], d1_sb.neg[1], d1_sb.neg[0]};
			end
		endcase
	end

	// sum of squares over three stages
	logic                   vld_s1, vld_s2, vld_s3;
	sb3_t                   sb_s1, sb_s2, sb_s3;
	logic [3:0][SQ_W-1:0]   sq_s1;
	logic [1:0][PS_W-1:0]   ps_s2;
	logic [TS_W-1:0]        tot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d1_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1 <= '{piv: d1_sb.piv, neg: qn_c, mag: qm_c, zero: d1_sb.zero};
			for (int l = 0; l < 4; l++) begin
				sq_s1[l] <= SQ_W'(qm_c[l]) * SQ_W'(qm_c[l]);
			end
			sb_s2    <= sb_s1;
			ps_s2[0] <= PS_W'(sq_s1[0]) + PS_W'(sq_s1[1]);
			ps_s2[1] <= PS_W'(sq_s1[2]) + PS_W'(sq_s1[3]);
			sb_s3    <= sb_s2;
			tot_s3   <= TS_W'(ps_s2[0]) + TS_W'(ps_s2[1]);
		end
	end

	sb3_t           r2_sb;
	logic           r2_vld;
	logic [NRW-1:0] r2_norm;

	rmq_isqrt #(.IN_W(TS_W), .SB_W($bits(sb3_t))) u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.rad(tot_s3), .in_sb(sb_s3),
		.out_vld(r2_vld), .root(r2_norm), .out_sb(r2_sb)
	);

	sb4_t                d2_in_sb, d2_sb;
	logic [3:0][N2W-1:0] d2_num;
	logic                d2_vld;
	logic [3:0][DW-1:0]  d2_quo;
	logic [3:0]          d2_ovf;

	assign d2_in_sb = '{
		piv:  r2_sb.piv,
		neg:  r2_sb.neg,
		zero: r2_sb.zero || (r2_norm == '0)
	};

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			d2_num[l] = {r2_sb.mag[l], {FB{1'b0}}};
		end
	end

	rmq_div #(
		.NUM_W(N2W), .DEN_W(NRW), .QUO_W(DW), .LANES(4), .SB_W($bits(sb4_t))
	) u_div_n (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(r2_vld),
		.num(d2_num), .den(r2_norm), .in_sb(d2_in_sb),
		.out_vld(d2_vld), .quo(d2_quo), .ovf(d2_ovf), .out_sb(d2_sb)
	);

	// sign, saturation and zero-divisor forcing
	logic [3:0][DW-1:0] res_c;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (d2_sb.zero) begin
				res_c[l] = '0;
			end else if (d2_sb.neg[l]) begin
				if (d2_ovf[l] || (d2_quo[l][DW-1] && (d2_quo[l][DW-2:0] != '0))) begin
					res_c[l] = OMIN;
				end else begin
					res_c[l] = DW'(-d2_quo[l]);
				end
			end else begin
				res_c[l] = (d2_ovf[l] || d2_quo[l][DW-1]) ? OMAX : d2_quo[l];
			end
		end
	end

	logic [3:0][DW-1:0] res_s4;
	piv_t               piv_s4;
	logic               zero_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4  <= res_c;
			piv_s4  <= d2_sb.piv;
			zero_s4 <= d2_sb.zero;
		end
	end

	assign quat_valid = vld_s4;
	assign quat_x     = res_s4[0];
	assign quat_y     = res_s4[1];
	assign quat_z     = res_s4[2];
	assign quat_w     = res_s4[3];
	assign pivot_used = piv_s4;
	assign status     = zero_s4;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import rmq_pkg::*;

	localparam int DW = 16;
	localparam int FB = 14;
	localparam int LATENCY = 101;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic signed [DW-1:0] w;
		piv_t                 piv;
		logic                 zero_div;
	} quat_t;

	typedef logic signed [DW-1:0] mat_t [9];

	logic clk = 0;
	logic arst_n = 0;
	logic mat_valid = 0;
	logic mat_ready;
	logic signed [DW-1:0] r00 = 0, r01 = 0, r02 = 0, r10 = 0, r11 = 0, r12 = 0;
	logic signed [DW-1:0] r20 = 0, r21 = 0, r22 = 0;
	logic quat_valid;
	logic quat_ready = 0;
	logic signed [DW-1:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0] pivot_used;
	logic status;

	quat_t expected_quats[$];
	int errors = 0;
	int quats_seen = 0;
	int matrices_sent = 0;
	int piv_hits[4];
	int zero_div_hits = 0;
	bit sender_idles = 1;
	bit receiver_idles = 1;
	int hold_cycles = 0;

	rotation_matrix_to_quaternion_unit uut (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_ready(mat_ready),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.quat_valid(quat_valid), .quat_ready(quat_ready),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.pivot_used(pivot_used), .status(status)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// (num << FB) / den toward zero, magnitude clipped to the pre-norm limit
	function automatic longint scaled_div(input longint num, input logic [63:0] den);
		logic [63:0] mag, quo;
		mag = (num < 0) ? -num : num;
		quo = (mag << FB) / den;
		if (quo > 64'(QLIM)) quo = 64'(QLIM);
		return (num < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic quat_t predict_quat(input mat_t m);
		quat_t r;
		longint a[9];
		longint tr, arg, na, nb, nc, v;
		longint q[4];
		int ia, ib, ic, pidx;
		logic [63:0] root, s, sumsq, nrm, mag;
		for (int i = 0; i < 9; i++) a[i] = m[i];
		tr = a[0] + a[4] + a[8];
		q = '{0, 0, 0, 0};
		r = '0;
		if (tr > 0) begin
			r.piv = PIV_W; arg = tr + (1 << FB);
			na = a[7] - a[5]; nb = a[2] - a[6]; nc = a[3] - a[1];
			ia = 0; ib = 1; ic = 2; pidx = 3;
		end else if (a[0] > a[4] && a[0] > a[8]) begin
			r.piv = PIV_X; arg = a[0] - a[4] - a[8] + (1 << FB);
			na = a[7] - a[5]; nb = a[1] + a[3]; nc = a[2] + a[6];
			ia = 3; ib = 1; ic = 2; pidx = 0;
		end else if (a[4] > a[8]) begin
			r.piv = PIV_Y; arg = a[4] - a[0] - a[8] + (1 << FB);
			na = a[2] - a[6]; nb = a[1] + a[3]; nc = a[5] + a[7];
			ia = 3; ib = 0; ic = 2; pidx = 1;
		end else begin
			r.piv = PIV_Z; arg = a[8] - a[0] - a[4] + (1 << FB);
			na = a[3] - a[1]; nb = a[2] + a[6]; nc = a[5] + a[7];
			ia = 3; ib = 0; ic = 1; pidx = 2;
		end
		if (arg < 0) arg = 0;
		root = int_sqrt(64'(arg) << FB);
		s = root * 2;
		if (s == 0) begin
			r.zero_div = 1;
			return r;
		end
		q[pidx] = ((root >> 1) > 64'(QLIM)) ? longint'(QLIM) : longint'(root >> 1);
		q[ia] = scaled_div(na, s);
		q[ib] = scaled_div(nb, s);
		q[ic] = scaled_div(nc, s);
		sumsq = 0;
		for (int k = 0; k < 4; k++) begin
			mag = (q[k] < 0) ? -q[k] : q[k];
			sumsq += mag * mag;
		end
		nrm = int_sqrt(sumsq);
		if (nrm == 0) begin
			r.zero_div = 1;
			return r;
		end
		for (int k = 0; k < 4; k++) begin
			v = scaled_div(q[k], nrm);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			case (k)
				0: r.x = v[DW-1:0];
				1: r.y = v[DW-1:0];
				2: r.z = v[DW-1:0];
				default: r.w = v[DW-1:0];
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on quat %0d: %s got %0d expected %0d", quats_seen, what, got, want);
		errors++;
	endtask

	// checker
	always @(posedge clk) begin
		quat_t e;
		if (quat_valid && quat_ready) begin
			if (expected_quats.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				e = expected_quats.pop_front();
				if (quat_x !== e.x) report_mismatch("quat_x", quat_x, e.x);
				if (quat_y !== e.y) report_mismatch("quat_y", quat_y, e.y);
				if (quat_z !== e.z) report_mismatch("quat_z", quat_z, e.z);
				if (quat_w !== e.w) report_mismatch("quat_w", quat_w, e.w);
				if (pivot_used !== e.piv) report_mismatch("pivot_used", pivot_used, e.piv);
				if (status !== e.zero_div) report_mismatch("status", status, e.zero_div);
				piv_hits[e.piv]++;
				if (e.zero_div) zero_div_hits++;
			end
			quats_seen++;
		end
	end

	// receiver: random stall bursts, or a long hold when asked
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				quat_ready <= 0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				quat_ready <= 1;
			end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 15);
				quat_ready <= 0;
				repeat (n - 1) @(posedge clk);
			end else begin
				quat_ready <= 1;
			end
		end
	end

	task automatic send_matrix(input mat_t m);
		int n;
		if (sender_idles && $urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 15);
			mat_valid <= 0;
			repeat (n) @(posedge clk);
		end
		mat_valid <= 1;
		r00 <= m[0]; r01 <= m[1]; r02 <= m[2];
		r10 <= m[3]; r11 <= m[4]; r12 <= m[5];
		r20 <= m[6]; r21 <= m[7]; r22 <= m[8];
		expected_quats.insert(expected_quats.size(), predict_quat(m));
		matrices_sent++;
		do @(posedge clk); while (!mat_ready);
	endtask

	task automatic stop_sending();
		mat_valid <= 0;
	endtask

	function automatic mat_t fill_matrix(input logic signed [DW-1:0] v);
		mat_t m;
		foreach (m[i]) m[i] = v;
		return m;
	endfunction

	function automatic mat_t random_matrix();
		mat_t m;
		foreach (m[i]) m[i] = DW'($urandom);
		return m;
	endfunction

	// near-rotation: large positive diagonal, or one diagonal element dominating, small off-diagonal noise
	function automatic mat_t rotation_like();
		mat_t m;
		int p;
		p = $urandom_range(0, 3);
		foreach (m[i]) m[i] = DW'($signed($urandom_range(0, 16383)) - 8192);
		if (p == 3) begin
			m[0] = DW'($urandom_range(8000, 16384)); m[4] = DW'($urandom_range(8000, 16384));
			m[8] = DW'($urandom_range(8000, 16384));
		end else begin
			m[0] = DW'(-$signed($urandom_range(0, 16384)));
			m[4] = DW'(-$signed($urandom_range(0, 16384)));
			m[8] = DW'(-$signed($urandom_range(0, 16384)));
			m[p * 4] = DW'($urandom_range(0, 16384));
		end
		return m;
	endfunction

	task automatic test_directed();
		mat_t m;
		send_matrix(fill_matrix(0));
		send_matrix(fill_matrix(16'sh7fff));
		send_matrix(fill_matrix(-16'sh8000));
		send_matrix(fill_matrix(-1));
		// identity and half-turns about each axis
		m = fill_matrix(0); m[0] = 16384; m[4] = 16384; m[8] = 16384; send_matrix(m);
		m = fill_matrix(0); m[0] = 16384; m[4] = -16384; m[8] = -16384; send_matrix(m);
		m = fill_matrix(0); m[0] = -16384; m[4] = 16384; m[8] = -16384; send_matrix(m);
		m = fill_matrix(0); m[0] = -16384; m[4] = -16384; m[8] = 16384; send_matrix(m);
		// equal most negative diagonal, a tie that falls to the z pivot
		m = fill_matrix(0); m[0] = -32768; m[4] = -32768; m[8] = -32768; send_matrix(m);
		// ties on the diagonal
		m = fill_matrix(100); m[0] = -5; m[4] = -5; m[8] = -5; send_matrix(m);
		m = fill_matrix(0); m[0] = -100; m[4] = -200; m[8] = -100; send_matrix(m);
		// trace exactly zero takes the diagonal branch
		m = fill_matrix(0); m[0] = 100; m[4] = -50; m[8] = -50; send_matrix(m);
		// big off-diagonal values against extreme diagonal values
		m = fill_matrix(16'sh7fff); m[0] = -32768; m[4] = -32768; m[8] = 16384;
		m[1] = -32768; send_matrix(m);
		m = fill_matrix(-16'sh8000); m[0] = 1; send_matrix(m);
	endtask

	task automatic test_random();
		for (int i = 0; i < 1100; i++)
			send_matrix(($urandom_range(0, 3) == 0) ? random_matrix() : rotation_like());
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 200; i++) send_matrix(rotation_like());
	endtask

	task automatic test_full_rate();
		sender_idles = 0;
		receiver_idles = 0;
		for (int i = 0; i < 150; i++) send_matrix(random_matrix());
		stop_sending();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_full_rate();
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d matrices, checked %0d quaternions", matrices_sent, quats_seen);
		$display("pivots w/x/y/z: %0d/%0d/%0d/%0d, zero divisor: %0d",
			piv_hits[0], piv_hits[1], piv_hits[2], piv_hits[3], zero_div_hits);
		if (errors == 0 && expected_quats.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("testbench failed");
		$finish;
	end

endmodule
